// File: src/mfpa_pkg.sv
// Package for the multi-frame pixel accumulator.
// Holds register indexes, reset values, precision codes and the beat flag struct.
// Depends on nothing; used by mfpa_seq and multi_frame_pixel_accumulator.
package mfpa_pkg;

    // Default frame store depth in pixels.
    localparam int DEF_MAX_PIXELS = 65536;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAMES_TO_SUM    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRECISION_MODE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXELS_PER_FRAME = 2'd2;

    // Register widths and reset values.
    localparam int FRAMES_W = 8;
    localparam int MODE_W   = 2;
    localparam int PPF_W    = 17;
    localparam logic [FRAMES_W-1:0] RST_FRAMES_TO_SUM    = 8'd1;
    localparam logic [MODE_W-1:0]   RST_PRECISION_MODE   = 2'd0;
    localparam logic [PPF_W-1:0]    RST_PIXELS_PER_FRAME = 17'd65536;

    // Precision codes. Bit 1 of the mode enables the square output.
    localparam logic [MODE_W-1:0] MODE_SUM16 = 2'd0;
    localparam int MODE_SQUARE_BIT = 1;

    // Field widths.
    localparam int PIX_W = 16;
    localparam int ACC_W = 32;

    // Position flags for one pixel beat.
    typedef struct packed {
        logic first_frame;
        logic last_frame;
        logic last_pixel;
    } t_beat_flags;

endpackage

// File: src/mfpa_seq.sv
// Raster sequencer: tracks pixel and frame position within a group.
// Produces the store address and position flags of the beat at the input.
// Depends on mfpa_pkg.
module mfpa_seq
    import mfpa_pkg::*;
#(
    parameter int MAX_PIXELS = DEF_MAX_PIXELS,
    parameter int AW = $clog2(MAX_PIXELS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic [FRAMES_W-1:0] i_frames_to_sum,
    input  logic [PPF_W-1:0]    i_pixels_per_frame,
    output logic [AW-1:0]       o_addr,
    output t_beat_flags         o_flags
);

    // Compare width wide enough for both the register and the store depth.
    localparam int CW = (AW + 1 > PPF_W) ? AW + 1 : PPF_W;

    logic [AW-1:0]       r_pixel_pos;
    logic [AW-1:0]       n_pixel_pos;
    logic [FRAMES_W-1:0] r_frame_pos;
    logic [FRAMES_W-1:0] n_frame_pos;
    logic [CW-1:0]       w_eff_pixels;
    logic [FRAMES_W:0]   w_eff_frames;
    logic                w_last_pixel;
    logic                w_last_frame;

    // Effective frame size: zero counts as one, anything above the store saturates.
    always_comb begin
        w_eff_pixels = CW'(i_pixels_per_frame);
        if (i_pixels_per_frame == '0) begin
            w_eff_pixels = CW'(1);
        end else if (CW'(i_pixels_per_frame) > CW'(MAX_PIXELS)) begin
            w_eff_pixels = CW'(MAX_PIXELS);
        end
    end

    // Effective group length: zero frames counts as one.
    assign w_eff_frames = (i_frames_to_sum == '0) ? (FRAMES_W+1)'(1)
                                                  : {1'b0, i_frames_to_sum};

    // Position flags of the current beat.
    assign w_last_pixel = (CW'(r_pixel_pos) + CW'(1)) >= w_eff_pixels;
    assign w_last_frame = ({1'b0, r_frame_pos} + (FRAMES_W+1)'(1)) >= w_eff_frames;

    assign o_addr              = r_pixel_pos;
    assign o_flags.first_frame = (r_frame_pos == '0);
    assign o_flags.last_frame  = w_last_frame;
    assign o_flags.last_pixel  = w_last_pixel;

    // Next position after an accepted beat.
    always_comb begin
        n_pixel_pos = r_pixel_pos;
        n_frame_pos = r_frame_pos;
        if (i_advance) begin
            if (w_last_pixel) begin
                n_pixel_pos = '0;
                n_frame_pos = w_last_frame ? '0 : r_frame_pos + FRAMES_W'(1);
            end else begin
                n_pixel_pos = r_pixel_pos + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_pos <= '0;
            r_frame_pos <= '0;
        end else begin
            r_pixel_pos <= n_pixel_pos;
            r_frame_pos <= n_frame_pos;
        end
    end

    // The last pixel of a frame wraps the pixel position back to zero.
    a_wrap_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && w_last_pixel |=> r_pixel_pos == '0)
        else $error("pixel position did not wrap after last pixel");

    // Inside a frame the frame position holds while the pixel position steps.
    a_step_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && !w_last_pixel
        |=> r_pixel_pos == $past(r_pixel_pos) + AW'(1) && $stable(r_frame_pos))
        else $error("pixel step changed the frame position");

endmodule

// File: src/multi_frame_pixel_accumulator.sv
// Multi-frame pixel accumulator, top level.
// Holds configuration registers, the frame stores and the three-stage read-modify-write pipe.
// Depends on mfpa_pkg and mfpa_seq.

// The block takes one pixel beat per clock and sums each pixel position over a group
// of frames_to_sum frames, keeping a 32-bit sum (16-bit wrap in precision mode 0) and a
// 32-bit sum of squares in two MAX_PIXELS x 32 frame stores. The first frame of a group
// overwrites the stores, so no clearing pass is needed after reset. A pixel moves
// through three register stages: position and address capture, store read with the
// 16x16 square, then add and write back into the output register. Results come out
// only during the last frame of a group, one per pixel, with frame_end on the last
// pixel of the frame. The sustained rate is one pixel per cycle; it is set by the
// store's single read and write port per cycle, with the freshly written total
// forwarded when consecutive beats hit the same address. Only a stalled, valid output
// register holds the pipe.
module multi_frame_pixel_accumulator
    import mfpa_pkg::*;
#(
    parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write channel.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Pixel input channel.
    input  logic                   i_pixel_valid,
    output logic                   o_pixel_stall,
    input  logic [PIX_W-1:0]       i_pixel_value,
    // Result output channel.
    output logic                   o_result_valid,
    input  logic                   i_result_stall,
    output logic [ACC_W-1:0]       o_pixel_sum,
    output logic [ACC_W-1:0]       o_pixel_square_sum,
    output logic                   o_frame_end
);

    localparam int AW = $clog2(MAX_PIXELS);

    // Configuration registers.
    logic [FRAMES_W-1:0] r_frames_to_sum;
    logic [MODE_W-1:0]   r_precision_mode;
    logic [PPF_W-1:0]    r_pixels_per_frame;

    // Pipeline control.
    logic        w_adv;
    logic        w_accept;
    logic [AW-1:0] w_seq_addr;
    t_beat_flags w_seq_flags;

    // Stage 1: captured beat.
    logic              r_s1_valid;
    logic [AW-1:0]     r_s1_addr;
    t_beat_flags       r_s1_flags;
    logic [PIX_W-1:0]  r_s1_pix;

    // Stage 2: store read data, square and forwarded totals.
    logic              r_s2_valid;
    logic [AW-1:0]     r_s2_addr;
    t_beat_flags       r_s2_flags;
    logic [PIX_W-1:0]  r_s2_pix;
    logic [ACC_W-1:0]  r_s2_sq;
    logic [ACC_W-1:0]  r_rd_sum;
    logic [ACC_W-1:0]  r_rd_sq;
    logic              r_fwd_hit;
    logic [ACC_W-1:0]  r_fwd_sum;
    logic [ACC_W-1:0]  r_fwd_sq;
    logic [ACC_W-1:0]  w_base_sum;
    logic [ACC_W-1:0]  w_base_sq;
    logic [ACC_W-1:0]  w_new_sum;
    logic [ACC_W-1:0]  w_new_sq;

    // Stage 3: output register.
    logic              r_s3_valid;
    logic [ACC_W-1:0]  r_s3_sum;
    logic [ACC_W-1:0]  r_s3_sq;
    logic              r_s3_frame_end;

    // Frame stores.
    logic [ACC_W-1:0] r_sum_mem [MAX_PIXELS];
    logic [ACC_W-1:0] r_sq_mem  [MAX_PIXELS];

    // The whole pipe moves unless a result sits stalled in the output register.
    assign w_adv         = !(r_s3_valid && i_result_stall);
    assign o_pixel_stall = !w_adv;
    assign w_accept      = i_pixel_valid && w_adv;
    assign o_cfg_ready   = 1'b1;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_to_sum    <= RST_FRAMES_TO_SUM;
            r_precision_mode   <= RST_PRECISION_MODE;
            r_pixels_per_frame <= RST_PIXELS_PER_FRAME;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FRAMES_TO_SUM:    r_frames_to_sum    <= i_cfg_data[FRAMES_W-1:0];
                CFG_PRECISION_MODE:   r_precision_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_PIXELS_PER_FRAME: r_pixels_per_frame <= i_cfg_data[PPF_W-1:0];
                default: ;
            endcase
        end
    end

    // Position tracking for the beat at the input.
    mfpa_seq #(
        .MAX_PIXELS (MAX_PIXELS),
        .AW         (AW)
    ) u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_advance          (w_accept),
        .i_frames_to_sum    (r_frames_to_sum),
        .i_pixels_per_frame (r_pixels_per_frame),
        .o_addr             (w_seq_addr),
        .o_flags            (w_seq_flags)
    );

    // Stage 1 valid and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_pixel_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_addr  <= w_seq_addr;
            r_s1_flags <= w_seq_flags;
            r_s1_pix   <= i_pixel_value;
        end
    end

    // Stage 2 valid and payload, with the square registered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_addr  <= r_s1_addr;
            r_s2_flags <= r_s1_flags;
            r_s2_pix   <= r_s1_pix;
            r_s2_sq    <= ACC_W'(r_s1_pix) * ACC_W'(r_s1_pix);
        end
    end

    // Sum store: read for stage 1, write back from stage 2.
    always_ff @(posedge i_clk) begin
        if (w_adv && r_s2_valid) begin
            r_sum_mem[r_s2_addr] <= w_new_sum;
        end
        if (w_adv && r_s1_valid) begin
            r_rd_sum <= r_sum_mem[r_s1_addr];
        end
    end

    // Square store: read for stage 1, write back from stage 2.
    always_ff @(posedge i_clk) begin
        if (w_adv && r_s2_valid) begin
            r_sq_mem[r_s2_addr] <= w_new_sq;
        end
        if (w_adv && r_s1_valid) begin
            r_rd_sq <= r_sq_mem[r_s1_addr];
        end
    end

    // Forward the total being written when the next beat reads the same address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (w_adv) begin
            r_fwd_hit <= r_s2_valid && (r_s2_addr == r_s1_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fwd_sum <= w_new_sum;
            r_fwd_sq  <= w_new_sq;
        end
    end

    // Accumulate: the first frame of a group starts from zero.
    always_comb begin
        w_base_sum = r_fwd_hit ? r_fwd_sum : r_rd_sum;
        w_base_sq  = r_fwd_hit ? r_fwd_sq  : r_rd_sq;
        if (r_s2_flags.first_frame) begin
            w_base_sum = '0;
            w_base_sq  = '0;
        end
        w_new_sum = w_base_sum + ACC_W'(r_s2_pix);
        w_new_sq  = w_base_sq + r_s2_sq;
        if (r_precision_mode == MODE_SUM16) begin
            w_new_sum[ACC_W-1:PIX_W] = '0;
        end
    end

    // Stage 3: only beats of the last frame of a group produce a result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s3_valid <= r_s2_valid && r_s2_flags.last_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_sum       <= w_new_sum;
            r_s3_sq        <= r_precision_mode[MODE_SQUARE_BIT] ? w_new_sq : '0;
            r_s3_frame_end <= r_s2_flags.last_pixel;
        end
    end

    assign o_result_valid     = r_s3_valid;
    assign o_pixel_sum        = r_s3_sum;
    assign o_pixel_square_sum = r_s3_sq;
    assign o_frame_end        = r_s3_frame_end;

    // An accepted beat always lands in stage 1.
    a_accept_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_valid)
        else $error("accepted pixel beat missing from stage 1");

    // A held pipe keeps stage 1 intact.
    a_hold_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_s1_valid) && $stable(r_s1_addr) && $stable(r_s1_pix))
        else $error("stage 1 changed while the pipe was held");

    // Back-to-back beats at the same address must take the forwarded total.
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_s1_valid && r_s2_valid && (r_s1_addr == r_s2_addr) |=> r_fwd_hit)
        else $error("same-address beats were not forwarded");

    // A held pipe leaves stage 2 and its forward flag alone.
    a_hold_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_s2_valid) && $stable(r_fwd_hit))
        else $error("stage 2 changed while the pipe was held");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-frame pixel accumulator.
// Walks a directed table, then random register settings and pixel beats, against a predictor.
// Depends on mfpa_pkg and multi_frame_pixel_accumulator.
module testbench;
    import mfpa_pkg::*;

    localparam int ITEM_TARGET   = 1150;
    localparam int CALM_FROM     = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 150;
    localparam int REPORT_LIMIT  = 10;
    localparam int CYCLE_LIMIT   = 400000;

    // Precision codes beyond the one the package names.
    localparam logic [MODE_W-1:0] MODE_SUM32   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SQUARES = 2'd2;
    localparam logic [MODE_W-1:0] MODE_THREE   = 2'd3;

    localparam logic [PIX_W-1:0] PIX_MAX = 16'hFFFF;

    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic [ACC_W-1:0] square_sum;
        logic             frame_end;
    } t_pixel_total;

    typedef enum logic {ROW_CFG, ROW_PIXEL} t_row_kind;

    // One row of the directed table: a register write or a pixel beat.
    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
        logic                   typed;
        t_pixel_total           total;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_pixel_valid;
    logic                   o_pixel_stall;
    logic [PIX_W-1:0]       i_pixel_value;
    logic                   o_result_valid;
    logic                   i_result_stall;
    logic [ACC_W-1:0]       o_pixel_sum;
    logic [ACC_W-1:0]       o_pixel_square_sum;
    logic                   o_frame_end;

    // Predictor state: per-pixel mirrors of the frame stores and the raster position.
    logic [ACC_W-1:0]    sum_mirror [DEF_MAX_PIXELS];
    logic [ACC_W-1:0]    square_mirror [DEF_MAX_PIXELS];
    int unsigned         pixel_pos;
    int unsigned         frame_pos;
    int unsigned         first_frame_span;
    logic [FRAMES_W-1:0] frames_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [PPF_W-1:0]    ppf_reg;

    t_pixel_total pending_totals [$];
    t_stim_row    directed_rows [$];
    int unsigned  pixels_sent = 0;
    int unsigned  mismatch_count = 0;
    bit           calm = 1'b0;
    bit           hold_req = 1'b0;

    multi_frame_pixel_accumulator u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_pixel_valid      (i_pixel_valid),
        .o_pixel_stall      (o_pixel_stall),
        .i_pixel_value      (i_pixel_value),
        .o_result_valid     (o_result_valid),
        .i_result_stall     (i_result_stall),
        .o_pixel_sum        (o_pixel_sum),
        .o_pixel_square_sum (o_pixel_square_sum),
        .o_frame_end        (o_frame_end)
    );

    always #1 i_clk = ~i_clk;

    // Effective frame size and group depth after the out-of-range rules.
    function automatic int unsigned pixels_in_frame(input logic [PPF_W-1:0] ppf);
        if (ppf == '0) return 1;
        if (ppf > DEF_MAX_PIXELS) return DEF_MAX_PIXELS;
        return ppf;
    endfunction

    function automatic int unsigned frames_in_group(input logic [FRAMES_W-1:0] frames);
        return (frames == '0) ? 1 : frames;
    endfunction

    // Accumulates one pixel into the mirrors and returns 1 when it yields a total.
    function automatic bit accumulate_pixel(input logic [PIX_W-1:0] pix,
                                            output t_pixel_total total);
        int unsigned      np;
        int unsigned      nf;
        int unsigned      addr;
        bit               last_pixel;
        bit               last_frame;
        logic [ACC_W-1:0] square;
        logic [ACC_W-1:0] sum_now;
        logic [ACC_W-1:0] square_now;
        np = pixels_in_frame(ppf_reg);
        nf = frames_in_group(frames_reg);
        addr = (pixel_pos >= DEF_MAX_PIXELS) ? DEF_MAX_PIXELS - 1 : pixel_pos;
        last_pixel = (pixel_pos + 1 >= np);
        last_frame = (frame_pos + 1 >= nf);
        square = ACC_W'(pix) * ACC_W'(pix);
        // The first frame of a group overwrites; later frames add.
        if (frame_pos == 0) begin
            sum_now = ACC_W'(pix);
            square_now = square;
            first_frame_span = addr + 1;
        end else begin
            sum_now = sum_mirror[addr] + ACC_W'(pix);
            square_now = square_mirror[addr] + square;
        end
        if (mode_reg == MODE_SUM16) sum_now[ACC_W-1:PIX_W] = '0;
        sum_mirror[addr] = sum_now;
        square_mirror[addr] = square_now;
        total.sum = sum_now;
        total.square_sum = mode_reg[MODE_SQUARE_BIT] ? square_now : '0;
        total.frame_end = last_pixel;
        // Advance the raster position.
        if (last_pixel) begin
            pixel_pos = 0;
            frame_pos = last_frame ? 0 : frame_pos + 1;
        end else begin
            pixel_pos = pixel_pos + 1;
        end
        return last_frame;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_INDEX_W-1:0] index,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row = '0;
        row.kind = ROW_CFG;
        row.index = index;
        row.data = data;
        return row;
    endfunction

    function automatic t_stim_row pixel_row(input logic [PIX_W-1:0] pix, input logic typed,
                                            input logic [ACC_W-1:0] sum,
                                            input logic [ACC_W-1:0] square_sum,
                                            input logic frame_end);
        t_stim_row row;
        row = '0;
        row.kind = ROW_PIXEL;
        row.data = CFG_DATA_W'(pix);
        row.typed = typed;
        row.total = '{sum, square_sum, frame_end};
        return row;
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0: return PIX_MAX;
            1: return '0;
            default: return PIX_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [FRAMES_W-1:0] random_frames();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 8'd255;
            2: return FRAMES_W'($urandom_range(0, 255));
            default: return FRAMES_W'($urandom_range(1, 5));
        endcase
    endfunction

    function automatic logic [PPF_W-1:0] random_ppf();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return 17'd65536;
            2: return 17'd131071;
            3: return PPF_W'($urandom_range(0, 131071));
            default: return PPF_W'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic void report_mismatch(input string what, input logic [ACC_W-1:0] want,
                                            input logic [ACC_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch %0d: %s expected %h got %h", mismatch_count, what, want, got);
    endfunction

    // Writes one register through the configuration channel and mirrors it.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_FRAMES_TO_SUM:    frames_reg = data[FRAMES_W-1:0];
            CFG_PRECISION_MODE:   mode_reg = data[MODE_W-1:0];
            CFG_PIXELS_PER_FRAME: ppf_reg = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offers one pixel beat, holds it until accepted, then records the expected total.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic typed,
                              input t_pixel_total typed_total);
        t_pixel_total total;
        bit           emits;
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_pixel_valid <= 1'b1;
        i_pixel_value <= pix;
        do @(posedge i_clk); while (o_pixel_stall);
        emits = accumulate_pixel(pix, total);
        if (typed) pending_totals.push_back(typed_total);
        else if (emits) pending_totals.push_back(total);
        pixels_sent++;
        if (pixels_sent >= CALM_FROM) calm = 1'b1;
        @(negedge i_clk);
    endtask

    // Stops offering pixels, waits for every expected total, then lets the pipe settle.
    task automatic drain_totals();
        i_pixel_valid <= 1'b0;
        while (pending_totals.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One random phase: new register settings while idle, then a run of pixels.
    task automatic run_random_phase(input int unsigned phase_no);
        logic [FRAMES_W-1:0] new_frames;
        logic [MODE_W-1:0]   new_mode;
        logic [PPF_W-1:0]    new_ppf;
        int unsigned         group_len;
        int unsigned         count;
        drain_totals();
        new_frames = frames_reg;
        new_mode = mode_reg;
        new_ppf = ppf_reg;
        if (phase_no == 1) begin
            // Deepest group: 255 single-pixel frames.
            new_frames = 8'd255;
            new_ppf = 17'd1;
        end else begin
            if ($urandom_range(0, 1) == 0) new_frames = random_frames();
            if ($urandom_range(0, 1) == 0 || pixels_in_frame(ppf_reg) > 64)
                new_ppf = random_ppf();
            if ($urandom_range(0, 1) == 0) new_mode = MODE_W'($urandom_range(0, 3));
        end
        // Long frames only in single-frame groups, and tiny frames in deep groups.
        if (frames_in_group(new_frames) > 1 && pixels_in_frame(new_ppf) > 64)
            new_ppf = PPF_W'($urandom_range(1, 16));
        if (frames_in_group(new_frames) > 8 && pixels_in_frame(new_ppf) > 2)
            new_ppf = PPF_W'($urandom_range(1, 2));
        // A later frame may only read pixels that its group's first frame wrote.
        if (frame_pos != 0 && pixels_in_frame(new_ppf) > first_frame_span)
            new_ppf = PPF_W'(first_frame_span);
        if (new_frames != frames_reg || $urandom_range(0, 3) == 0)
            write_reg(CFG_FRAMES_TO_SUM, CFG_DATA_W'(new_frames));
        if (new_mode != mode_reg || $urandom_range(0, 3) == 0)
            write_reg(CFG_PRECISION_MODE, CFG_DATA_W'(new_mode));
        if (new_ppf != ppf_reg || $urandom_range(0, 3) == 0)
            write_reg(CFG_PIXELS_PER_FRAME, new_ppf);
        // Mostly whole groups, sometimes a ragged run.
        group_len = frames_in_group(frames_reg) * pixels_in_frame(ppf_reg);
        if (group_len <= 60 && $urandom_range(0, 3) != 0)
            count = group_len * $urandom_range(1, 3);
        else if (group_len <= 600 && $urandom_range(0, 1) == 0)
            count = group_len;
        else
            count = $urandom_range(3, 60);
        // Keep the whole run close to the item target.
        if (pixels_sent + count > ITEM_TARGET) count = ITEM_TARGET - pixels_sent;
        repeat (count) send_pixel(random_pixel(), 1'b0, '0);
    endtask

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin : result_sink
        int unsigned burst_left;
        int unsigned held;
        burst_left = 0;
        i_result_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_result_stall <= 1'b1;
                held = 0;
                while (held < LONG_HOLD) begin
                    @(negedge i_clk);
                    held++;
                end
                hold_req = 1'b0;
                i_result_stall <= 1'b0;
            end else if (burst_left != 0) begin
                i_result_stall <= 1'b1;
                burst_left--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_result_stall <= 1'b1;
                burst_left = $urandom_range(1, 12) - 1;
            end else begin
                i_result_stall <= 1'b0;
            end
        end
    end

    // Compare every accepted result beat with the oldest expected total.
    always @(posedge i_clk) begin
        t_pixel_total seen;
        t_pixel_total want;
        if (i_rst_n && o_result_valid && !i_result_stall) begin
            seen = '{o_pixel_sum, o_pixel_square_sum, o_frame_end};
            if (pending_totals.size() == 0) begin
                report_mismatch("result beat with nothing expected, pixel_sum", '0, seen.sum);
            end else begin
                want = pending_totals.pop_front();
                if (seen.sum !== want.sum)
                    report_mismatch("pixel_sum", want.sum, seen.sum);
                if (seen.square_sum !== want.square_sum)
                    report_mismatch("pixel_square_sum", want.square_sum, seen.square_sum);
                if (seen.frame_end !== want.frame_end)
                    report_mismatch("frame_end", ACC_W'(want.frame_end), ACC_W'(seen.frame_end));
            end
        end
    end

    // Cycle limit for a hung block.
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        t_stim_row   row;
        int unsigned phase_no;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_pixel_valid = 1'b0;
        i_pixel_value = '0;
        pixel_pos = 0;
        frame_pos = 0;
        first_frame_span = 0;
        frames_reg = RST_FRAMES_TO_SUM;
        mode_reg = RST_PRECISION_MODE;
        ppf_reg = RST_PIXELS_PER_FRAME;

        // Directed table. Reset settings: one frame per group, 16-bit sums, full frame.
        directed_rows.push_back(pixel_row(PIX_MAX, 1'b1, 32'h0000_FFFF, '0, 1'b0));
        directed_rows.push_back(pixel_row('0, 1'b1, '0, '0, 1'b0));
        directed_rows.push_back(cfg_row(CFG_PRECISION_MODE, CFG_DATA_W'(MODE_SQUARES)));
        directed_rows.push_back(pixel_row(PIX_MAX, 1'b1, 32'h0000_FFFF, 32'hFFFE_0001, 1'b0));
        // Frame size zero acts as one, and the position is already past the last pixel.
        directed_rows.push_back(cfg_row(CFG_PIXELS_PER_FRAME, '0));
        directed_rows.push_back(pixel_row(16'd2, 1'b1, 32'd2, 32'd4, 1'b1));
        // Zero frames acts as one; mode three reports squares like mode two.
        directed_rows.push_back(cfg_row(CFG_FRAMES_TO_SUM, '0));
        directed_rows.push_back(cfg_row(CFG_PRECISION_MODE, CFG_DATA_W'(MODE_THREE)));
        directed_rows.push_back(pixel_row(16'd3, 1'b1, 32'd3, 32'd9, 1'b1));
        // Three frames of two pixels with 16-bit wrap; squares stored but not shown.
        directed_rows.push_back(cfg_row(CFG_FRAMES_TO_SUM, 17'd3));
        directed_rows.push_back(cfg_row(CFG_PRECISION_MODE, CFG_DATA_W'(MODE_SUM16)));
        directed_rows.push_back(cfg_row(CFG_PIXELS_PER_FRAME, 17'd2));
        directed_rows.push_back(pixel_row(PIX_MAX, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(pixel_row(16'd1, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(pixel_row(PIX_MAX, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(pixel_row(16'd2, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(pixel_row(16'd3, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(pixel_row(16'd4, 1'b0, '0, '0, 1'b0));
        // Frame size above the store saturates; 32-bit sums.
        directed_rows.push_back(cfg_row(CFG_FRAMES_TO_SUM, 17'd1));
        directed_rows.push_back(cfg_row(CFG_PRECISION_MODE, CFG_DATA_W'(MODE_SUM32)));
        directed_rows.push_back(cfg_row(CFG_PIXELS_PER_FRAME, 17'd131071));
        directed_rows.push_back(pixel_row(16'h8000, 1'b1, 32'h0000_8000, '0, 1'b0));
        // Change group depth and shrink the frame in the middle of the first frame.
        directed_rows.push_back(cfg_row(CFG_FRAMES_TO_SUM, 17'd2));
        directed_rows.push_back(cfg_row(CFG_PIXELS_PER_FRAME, 17'd3));
        directed_rows.push_back(pixel_row(PIX_MAX, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(pixel_row(PIX_MAX, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(pixel_row(PIX_MAX, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(pixel_row(16'h1234, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(pixel_row(PIX_MAX, 1'b0, '0, '0, 1'b0));

        // Reset is held, then released on a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; register writes wait until the block is idle.
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG) begin
                if (i > 0 && directed_rows[i-1].kind == ROW_PIXEL) drain_totals();
                write_reg(row.index, row.data);
            end else begin
                send_pixel(row.data[PIX_W-1:0], row.typed, row.total);
            end
        end

        // Back-pressure: the result side holds off while pixels keep coming.
        drain_totals();
        write_reg(CFG_FRAMES_TO_SUM, 17'd1);
        write_reg(CFG_PRECISION_MODE, CFG_DATA_W'(MODE_SQUARES));
        write_reg(CFG_PIXELS_PER_FRAME, 17'd7);
        hold_req = 1'b1;
        repeat (60) send_pixel(random_pixel(), 1'b0, '0);

        // Random settings and pixel runs.
        phase_no = 0;
        while (pixels_sent < ITEM_TARGET) begin
            run_random_phase(phase_no);
            phase_no++;
        end

        drain_totals();
        if (mismatch_count == 0 && pending_totals.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: multi_frame_pixel_accumulator.f
src/mfpa_pkg.sv
src/mfpa_seq.sv
src/multi_frame_pixel_accumulator.sv
sim/testbench.sv
